// ----- src/pf_pkg.sv -----
package pf_pkg;

    // Key square geometry
    localparam int SQ_DIM   = 5;
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = SQ_DIM * CHAR_W;
    localparam int IDX_W    = 3;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LAST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT  = 3'd5;

    localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'd4;

    typedef logic [IDX_W-1:0]                   t_idx;
    typedef logic [CHAR_W-1:0]                  t_char;
    typedef logic [SQ_DIM-1:0][ROW_W-1:0]       t_square;

    // How a pair is transformed
    typedef enum logic [1:0] {
        KIND_MISSING,
        KIND_SAME_ROW,
        KIND_SAME_COL,
        KIND_RECT
    } t_kind;

    // One classified pair, as it travels from the front to the back
    typedef struct packed {
        t_kind kind;
        t_char first;
        t_char second;
        t_idx  row_a;
        t_idx  col_a;
        t_idx  row_b;
        t_idx  col_b;
        logic  last;
    } t_class;

    // Moves a row or column index one place, wrapping around the square.
    function automatic t_idx pf_step(input t_idx x, input logic dec);
        t_idx r;
        if (dec) begin
            r = (x == IDX_FIRST) ? IDX_LAST : x - 3'd1;
        end else begin
            r = (x == IDX_LAST) ? IDX_FIRST : x + 3'd1;
        end
        return r;
    endfunction

    // Reads one letter of the square.
    function automatic t_char pf_cell(input t_square sq, input t_idx r, input t_idx c);
        return sq[r][c*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ----- src/pf_front.sv -----
module pf_front
    import pf_pkg::*;
(
    input  t_square i_square,
    input  t_char   i_first,
    input  t_char   i_second,
    input  logic    i_last,
    output t_class  o_class
);

    // Finds the last row-major occurrence of a letter in the square.
    function automatic logic [2*IDX_W:0] locate(input t_square sq, input t_char ch);
        logic found;
        t_idx row;
        t_idx col;
        found = 1'b0;
        row   = IDX_FIRST;
        col   = IDX_FIRST;
        for (int r = 0; r < SQ_DIM; r++) begin
            for (int c = 0; c < SQ_DIM; c++) begin
                if (pf_cell(sq, t_idx'(r), t_idx'(c)) == ch) begin
                    found = 1'b1;
                    row   = t_idx'(r);
                    col   = t_idx'(c);
                end
            end
        end
        return {found, row, col};
    endfunction

    logic found_a;
    logic found_b;
    t_idx row_a;
    t_idx col_a;
    t_idx row_b;
    t_idx col_b;

    assign {found_a, row_a, col_a} = locate(i_square, i_first);
    assign {found_b, row_b, col_b} = locate(i_square, i_second);

    // Classify the pair by the Playfair rule that applies.
    always_comb begin
        o_class.first  = i_first;
        o_class.second = i_second;
        o_class.row_a  = row_a;
        o_class.col_a  = col_a;
        o_class.row_b  = row_b;
        o_class.col_b  = col_b;
        o_class.last   = i_last;
        priority if (!found_a || !found_b) begin
            o_class.kind = KIND_MISSING;
        end else if (row_a == row_b) begin
            o_class.kind = KIND_SAME_ROW;
        end else if (col_a == col_b) begin
            o_class.kind = KIND_SAME_COL;
        end else begin
            o_class.kind = KIND_RECT;
        end
    end

endmodule

// ----- src/pf_queue.sv -----
module pf_queue
    import pf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_class i_data,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_class o_data
);

    t_class     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- src/pf_back.sv -----
module pf_back
    import pf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_square i_square,
    input  logic    i_decrypt,
    input  logic    i_q_valid,
    input  t_class  i_q_data,
    output logic    o_pop,
    input  logic    i_stall,
    output logic    o_valid,
    output t_char   o_first,
    output t_char   o_second,
    output logic    o_missing,
    output logic    o_last
);

    logic  r_valid;
    t_char r_first;
    t_char r_second;
    logic  r_missing;
    logic  r_last;
    t_char n_first;
    t_char n_second;

    assign o_pop = i_q_valid && (!r_valid || !i_stall);

    // Transform the pair by its class.
    always_comb begin
        unique case (i_q_data.kind)
            KIND_MISSING: begin
                n_first  = i_q_data.first;
                n_second = i_q_data.second;
            end
            KIND_SAME_ROW: begin
                n_first  = pf_cell(i_square, i_q_data.row_a,
                                   pf_step(i_q_data.col_a, i_decrypt));
                n_second = pf_cell(i_square, i_q_data.row_b,
                                   pf_step(i_q_data.col_b, i_decrypt));
            end
            KIND_SAME_COL: begin
                n_first  = pf_cell(i_square, pf_step(i_q_data.row_a, i_decrypt),
                                   i_q_data.col_a);
                n_second = pf_cell(i_square, pf_step(i_q_data.row_b, i_decrypt),
                                   i_q_data.col_b);
            end
            default: begin
                n_first  = pf_cell(i_square, i_q_data.row_a, i_q_data.col_b);
                n_second = pf_cell(i_square, i_q_data.row_b, i_q_data.col_a);
            end
        endcase
    end

    // Output register: holds a beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first   <= n_first;
            r_second  <= n_second;
            r_missing <= (i_q_data.kind == KIND_MISSING);
            r_last    <= i_q_data.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_first   = r_first;
    assign o_second  = r_second;
    assign o_missing = r_missing;
    assign o_last    = r_last;

endmodule

// ----- src/playfair_digraph_cipher.sv -----
// Playfair digraph transform, one letter pair per beat.
//
// Input channel: i_in_valid / o_in_stall carry a pair of raw bytes and a
// last-pair flag. Output channel: o_out_valid / i_out_stall carry the
// transformed pair, a flag for a letter absent from the square (letters then
// pass through unchanged) and a copy of the last-pair flag.
// The key square rows and the decrypt mode are written through the plain
// write port (index 0 to 4 for rows, 5 for mode). The user must write them
// only while the block is idle; the block itself does not enforce this.
// A pair is located in the square and classified in the cycle it is taken,
// then waits in a two-entry queue; the back end picks the output letters and
// loads the output register. An accepted input beat reaches o_out_valid via
// the queue and the output register. Throughput is one pair per cycle while
// the receiver does not stall. On a stall the output register holds its beat,
// the queue fills, and o_in_stall rises once both queue entries are taken.
// Synchronous reset empties the queue and the output register and clears
// the square and the mode to zero.
module playfair_digraph_cipher
    import pf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_first_letter,
    input  logic [7:0]            i_second_letter,
    input  logic                  i_last_pair,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_first,
    output logic [7:0]            o_out_second,
    output logic                  o_letter_missing,
    output logic                  o_last_out
);

    t_square r_square;
    logic    r_decrypt;
    t_class  front_class;
    t_class  q_data;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    in_accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square  <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index <= CFG_ROW_LAST) begin
                r_square[i_cfg_index] <= i_cfg_data;
            end else if (i_cfg_index == CFG_DECRYPT) begin
                r_decrypt <= i_cfg_data[0];
            end
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    pf_front u_front (
        .i_square (r_square),
        .i_first  (i_first_letter),
        .i_second (i_second_letter),
        .i_last   (i_last_pair),
        .o_class  (front_class)
    );

    pf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_class),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    pf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_square  (r_square),
        .i_decrypt (r_decrypt),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (q_pop),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_first   (o_out_first),
        .o_second  (o_out_second),
        .o_missing (o_letter_missing),
        .o_last    (o_last_out)
    );

    // A full queue always has an entry to offer the back end.
    a_full_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> q_valid)
        else $error("queue full but empty");

    // An input beat into an idle block shows up after the queue and output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !q_valid && !o_out_valid) |-> ##2 o_out_valid)
        else $error("result missing after idle accept");

    // The back end only pops entries that exist.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ----- test/tb_playfair_digraph_cipher.sv -----
`timescale 1ns / 100ps

module tb_playfair_digraph_cipher;
    import pf_pkg::*;

    // Index values beyond the mode register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_DECRYPT + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    // Cycles with no beat on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Length of the deliberate receiver hold-off.
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        SQ_CLASSIC,
        SQ_DISTINCT,
        SQ_REPEATS,
        SQ_ALL_ONES,
        SQ_ZERO
    } t_square_style;

    typedef struct {
        t_char first;
        t_char second;
        logic  missing;
        logic  last;
    } t_pair_result;

    // Mirror of the key square and mode, plus the pairs still owed by the block.
    class digraph_scoreboard;
        bit [ROW_W-1:0] key_rows[SQ_DIM];
        bit             decrypt_on;
        t_pair_result   expected_pairs[$];
        int             fail_count;

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx <= CFG_ROW_LAST) begin
                key_rows[idx] = data;
            end else if (idx == CFG_DECRYPT) begin
                decrypt_on = data[0];
            end
        endfunction

        function t_char key_cell(int r, int c);
            return key_rows[r][CHAR_W*c +: CHAR_W];
        endfunction

        // The last match in row-major order wins.
        function bit find_letter(t_char ch, output int row, output int col);
            bit found;
            found = 1'b0;
            row = 0;
            col = 0;
            for (int r = 0; r < SQ_DIM; r++) begin
                for (int c = 0; c < SQ_DIM; c++) begin
                    if (key_cell(r, c) == ch) begin
                        row = r;
                        col = c;
                        found = 1'b1;
                    end
                end
            end
            return found;
        endfunction

        // Works out the transformed pair for an accepted input beat.
        function void note_pair(t_char a, t_char b, logic last);
            t_pair_result res;
            int ra, ca, rb, cb, step;
            bit fa, fb;
            step = decrypt_on ? SQ_DIM - 1 : 1;
            fa = find_letter(a, ra, ca);
            fb = find_letter(b, rb, cb);
            res.first = a;
            res.second = b;
            res.missing = 1'b0;
            res.last = last;
            if (!fa || !fb) begin
                res.missing = 1'b1;
            end else if (ra == rb) begin
                res.first = key_cell(ra, (ca + step) % SQ_DIM);
                res.second = key_cell(rb, (cb + step) % SQ_DIM);
            end else if (ca == cb) begin
                res.first = key_cell((ra + step) % SQ_DIM, ca);
                res.second = key_cell((rb + step) % SQ_DIM, cb);
            end else begin
                res.first = key_cell(ra, cb);
                res.second = key_cell(rb, ca);
            end
            expected_pairs.push_back(res);
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
            fail_count++;
        endfunction

        // Compares an output beat with the oldest pending pair.
        function void check_pair(t_char f, t_char s, logic miss, logic last);
            t_pair_result want;
            if (expected_pairs.size() == 0) begin
                $display("%0t: output beat %02h %02h with no pair pending, expected none",
                         $time, f, s);
                fail_count++;
                return;
            end
            want = expected_pairs.pop_front();
            if (f !== want.first) report("out_first", want.first, f);
            if (s !== want.second) report("out_second", want.second, s);
            if (miss !== want.missing) report("letter_missing", 8'(want.missing), 8'(miss));
            if (last !== want.last) report("last_out", 8'(want.last), 8'(last));
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_first_letter = '0;
    logic [7:0]            i_second_letter = '0;
    logic                  i_last_pair = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_out_first;
    logic [7:0]            o_out_second;
    logic                  o_letter_missing;
    logic                  o_last_out;

    digraph_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    playfair_digraph_cipher i_dut (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Beat monitor on both channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_pair(o_out_first, o_out_second, o_letter_missing, o_last_out);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_pair(i_first_letter, i_second_letter, i_last_pair);
            end
        end
    end

    // Watchdog: ends a run in which no beat moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        sb.note_config(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one pair and returns at the edge where it is taken.
    task automatic send_pair(input t_char a, input t_char b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_letter <= a;
        i_second_letter <= b;
        i_last_pair <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stops offering and waits until every pending pair has come out.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Builds a key square of the given style and loads it with the mode.
    task automatic load_square(input t_square_style style, input bit dec);
        bit [ROW_W-1:0]        rows[SQ_DIM];
        bit                    used[256];
        t_char                 pool[6];
        t_char                 ch;
        string                 alpha;
        logic [CFG_DATA_W-1:0] data;
        alpha = "ABCDEFGHIKLMNOPQRSTUVWXYZ";
        pool[0] = 8'h00;
        pool[1] = 8'hFF;
        for (int i = 2; i < 6; i++) pool[i] = t_char'($urandom_range(255));
        for (int r = 0; r < SQ_DIM; r++) begin
            for (int c = 0; c < SQ_DIM; c++) begin
                case (style)
                    SQ_CLASSIC: ch = alpha[r*SQ_DIM + c];
                    SQ_DISTINCT: begin
                        do ch = t_char'($urandom_range(255)); while (used[ch]);
                        used[ch] = 1'b1;
                    end
                    SQ_REPEATS: ch = pool[$urandom_range(5)];
                    SQ_ALL_ONES: ch = 8'hFF;
                    default: ch = 8'h00;
                endcase
                rows[r][CHAR_W*c +: CHAR_W] = ch;
            end
        end
        for (int r = 0; r < SQ_DIM; r++) cfg_write(CFG_IDX_W'(r), rows[r]);
        // Upper data bits of the mode write are don't-care and get random values.
        data = CFG_DATA_W'({$urandom, $urandom});
        data[0] = dec;
        cfg_write(CFG_DECRYPT, data);
        cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
                  CFG_DATA_W'({$urandom, $urandom}));
    endtask

    // Random messages: mostly letters from the square, biased toward shared
    // rows and columns, with some stray bytes that miss the square.
    task automatic run_batch(input int n_items, input int hold_at);
        int    sent, len, pick, r1, c1, r2, c2;
        t_char a, b;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                if (sent == hold_at) hold_req = 1'b1;
                r1 = $urandom_range(SQ_DIM - 1);
                c1 = $urandom_range(SQ_DIM - 1);
                r2 = $urandom_range(SQ_DIM - 1);
                c2 = $urandom_range(SQ_DIM - 1);
                pick = $urandom_range(99);
                if (pick < 35) begin
                    r2 = r1;
                end else if (pick < 65) begin
                    c2 = c1;
                end
                a = sb.key_cell(r1, c1);
                b = sb.key_cell(r2, c2);
                pick = $urandom_range(99);
                if (pick < 8) begin
                    a = t_char'($urandom_range(255));
                    b = t_char'($urandom_range(255));
                end else if (pick < 14) begin
                    a = t_char'($urandom_range(255));
                end else if (pick < 20) begin
                    b = t_char'($urandom_range(255));
                end
                send_pair(a, b, k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        send_idle_pct = 24;
        recv_idle_pct = 88;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Square as left by reset: every cell holds zero.
        send_pair(8'h00, 8'h00, 1'b0);
        send_pair(8'h00, 8'hFF, 1'b1);
        drain();

        // Directed pairs on the textbook square, encrypting.
        load_square(SQ_CLASSIC, 1'b0);
        send_pair("A", "B", 1'b0);
        send_pair("E", "A", 1'b0);
        send_pair("A", "F", 1'b0);
        send_pair("V", "A", 1'b0);
        send_pair("A", "G", 1'b0);
        send_pair("Z", "A", 1'b0);
        send_pair("M", "M", 1'b0);
        send_pair("J", "A", 1'b0);
        send_pair("A", "J", 1'b0);
        send_pair(8'h00, 8'hFF, 1'b0);
        send_pair(8'hFF, 8'h00, 1'b1);
        drain();

        // Same square, decrypting.
        cfg_write(CFG_DECRYPT, 40'h1);
        send_pair("B", "A", 1'b0);
        send_pair("A", "E", 1'b0);
        send_pair("F", "A", 1'b0);
        send_pair("A", "V", 1'b0);
        send_pair("G", "A", 1'b0);
        send_pair("M", "M", 1'b0);
        send_pair("Y", "Q", 1'b1);
        drain();

        // Sender idles little, receiver idles a lot; one long hold-off.
        load_square(SQ_DISTINCT, 1'b0);
        run_batch(285, 100);
        drain();
        load_square(SQ_REPEATS, 1'b1);
        run_batch(285, -1);
        drain();

        // Roles swapped.
        send_idle_pct = 88;
        recv_idle_pct = 24;
        load_square(SQ_CLASSIC, 1'b1);
        run_batch(285, -1);
        drain();
        load_square(SQ_ALL_ONES, 1'b0);
        run_batch(100, -1);
        drain();
        load_square(SQ_DISTINCT, 1'b1);
        run_batch(285, -1);
        drain();

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_square(SQ_REPEATS, 1'b0);
        run_batch(285, -1);
        drain();
        load_square(SQ_ZERO, 1'b1);
        run_batch(100, -1);
        drain();

        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
